// ===== rtl/kct_pkg.sv =====
// Shared types, constants and codes for the keyed counter table.
`timescale 1ns / 1ps

package kct_pkg;

   localparam int ENTRIES    = 16;
   localparam int TAG_BITS   = 16;
   localparam int COUNT_BITS = 31;

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   localparam int FIELD_TAG_W    = 16;
   localparam int FIELD_AMOUNT_W = 31;
   localparam int FIELD_COUNT_W  = 31;
   localparam int STATUS_W       = 3;

   // The shared unit is wide enough for any tag or count, plus a borrow bit.
   localparam int ALU_W = 33;
   localparam int RES_W = ALU_W + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TAG     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_AMOUNT = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 3'd4;

   typedef enum logic {
      FUNC_ADD    = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_RESP
   } state_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [RES_W-1:0] res;
      logic             zero;
      logic             neg;
   } alu_rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  set_valid;
      logic                  clr_valid;
      logic [IDX_BITS-1:0]   addr;
      logic [TAG_BITS-1:0]   tag;
      logic [COUNT_BITS-1:0] count;
   } store_wr_type;

endpackage

// ===== rtl/keyed_counter_table_unit.sv =====
// Top level of the keyed counter table: sequencer, scan control and response register.
//
//   Channel | Ports                               | Direction
//   --------+-------------------------------------+----------
//   request | req_valid req_stall req_func        | in
//           | req_tag req_amount                  |
//   result  | rsp_valid rsp_stall rsp_new_count   | out
//           | rsp_status                          |
//
// A rejected request (zero tag or zero amount) is answered in the cycle after its beat.
// Otherwise the entries are scanned one per cycle through the memory read port and the shared
// add/subtract unit: a hit, or a new entry on an add, passes through an update step before
// the result; other misses answer directly, and idle follows each result beat.
// Synchronous reset clears all valid bits and the sequencer; req_stall stays high from the
// accepted beat until the result beat is taken, and a stalled result holds its value.
`timescale 1ns / 1ps

module keyed_counter_table_unit
   import kct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [FIELD_TAG_W-1:0]    req_tag,
   input  logic [FIELD_AMOUNT_W-1:0] req_amount,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [FIELD_COUNT_W-1:0]  rsp_new_count,
   output logic [STATUS_W-1:0]       rsp_status
);

   state_type state_ff, state_in;

   func_type                  func_ff, func_in;
   logic [TAG_BITS-1:0]       key_ff, key_in;
   logic [FIELD_AMOUNT_W-1:0] amt_ff, amt_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [IDX_BITS-1:0]       rd_idx_ff, rd_idx_in;
   logic                      free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]       free_idx_ff, free_idx_in;
   logic                      hit_ff, hit_in;
   logic [IDX_BITS-1:0]       hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0]     cur_count_ff, cur_count_in;
   logic [FIELD_COUNT_W-1:0]  out_count_ff, out_count_in;
   logic [STATUS_W-1:0]       out_status_ff, out_status_in;

   logic [TAG_BITS-1:0]   req_key;
   logic                  req_reject;
   logic                  scan_more;
   logic [IDX_BITS-1:0]   cnt_idx;
   logic                  tag_hit;
   logic                  scan_miss;
   logic                  sat;
   logic [COUNT_BITS-1:0] add_count;
   logic                  remove_frees;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;
   store_wr_type          store_wr;
   logic                  rd_en;
   logic [TAG_BITS-1:0]   rd_tag;
   logic [COUNT_BITS-1:0] rd_count;
   logic [ENTRIES-1:0]    valid;

   kct_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   kct_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (store_wr),
      .rd_en    (rd_en),
      .rd_addr  (cnt_idx),
      .rd_tag   (rd_tag),
      .rd_count (rd_count),
      .valid    (valid)
   );

   assign req_key    = TAG_BITS'(req_tag);
   assign req_reject = (req_key == '0) || (req_amount == '0);

   assign cnt_idx   = cnt_ff[IDX_BITS-1:0];
   assign scan_more = (cnt_ff < CNT_BITS'(ENTRIES));
   // The read is registered, so the compare looks at the entry read in the previous cycle.
   assign tag_hit   = rd_pend_ff && valid[rd_idx_ff] && alu_rsp.zero;
   assign scan_miss = !rd_pend_ff && !scan_more;

   assign sat          = (alu_rsp.res > RES_W'(COUNT_MAX));
   assign add_count    = sat ? COUNT_MAX : alu_rsp.res[COUNT_BITS-1:0];
   assign remove_frees = alu_rsp.neg || alu_rsp.zero;

   assign rd_en = (state_ff == S_SCAN) && scan_more;

   always_comb begin
      alu_req.op = ALU_SUB;
      alu_req.a  = ALU_W'(rd_tag);
      alu_req.b  = ALU_W'(key_ff);
      if (state_ff == S_UPDATE) begin
         alu_req.op = (func_ff == FUNC_ADD) ? ALU_ADD : ALU_SUB;
         alu_req.a  = ALU_W'(cur_count_ff);
         alu_req.b  = ALU_W'(amt_ff);
      end
   end

   always_comb begin
      store_wr           = '0;
      store_wr.addr      = hit_ff ? hit_idx_ff : free_idx_ff;
      store_wr.tag       = key_ff;
      store_wr.count     = (func_ff == FUNC_ADD) ? add_count : alu_rsp.res[COUNT_BITS-1:0];
      if (state_ff == S_UPDATE) begin
         if (func_ff == FUNC_ADD) begin
            store_wr.wr_en     = 1'b1;
            store_wr.set_valid = 1'b1;
         end else if (remove_frees) begin
            store_wr.clr_valid = 1'b1;
         end else begin
            store_wr.wr_en = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = req_reject ? S_RESP : S_SCAN;
            end
         end
         S_SCAN: begin
            if (tag_hit) begin
               state_in = S_UPDATE;
            end else if (scan_miss) begin
               if ((func_ff == FUNC_REMOVE) || !free_found_ff) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_stall = 1'b0;
         S_RESP:   rsp_valid = 1'b1;
         S_SCAN,
         S_UPDATE: req_stall = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      func_in       = func_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      cnt_in        = cnt_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      cur_count_in  = cur_count_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in       = func_type'(req_func);
               key_in        = req_key;
               amt_in        = req_amount;
               cnt_in        = '0;
               rd_pend_in    = 1'b0;
               free_found_in = 1'b0;
               hit_in        = 1'b0;
               out_count_in  = '0;
               priority if (req_key == '0) begin
                  out_status_in = STATUS_BAD_TAG;
               end else if (req_amount == '0) begin
                  out_status_in = STATUS_ZERO_AMOUNT;
               end else begin
                  out_status_in = STATUS_OK;
               end
            end
         end
         S_SCAN: begin
            if (scan_more) begin
               cnt_in     = cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_idx;
               // The lowest free slot is the first invalid one seen on the way.
               if (!free_found_ff && !valid[cnt_idx]) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cnt_idx;
               end
            end else begin
               rd_pend_in = 1'b0;
            end
            if (tag_hit) begin
               hit_in       = 1'b1;
               hit_idx_in   = rd_idx_ff;
               cur_count_in = rd_count;
            end else if (scan_miss) begin
               cur_count_in = '0;
               if (func_ff == FUNC_REMOVE) begin
                  out_status_in = STATUS_NOT_FOUND;
               end else if (!free_found_ff) begin
                  out_status_in = STATUS_FULL;
               end
            end
         end
         S_UPDATE: begin
            out_status_in = STATUS_OK;
            if (func_ff == FUNC_ADD) begin
               out_count_in = FIELD_COUNT_W'(add_count);
            end else if (remove_frees) begin
               out_count_in = '0;
            end else begin
               out_count_in = FIELD_COUNT_W'(alu_rsp.res[COUNT_BITS-1:0]);
            end
         end
         S_RESP: begin
            out_count_in = out_count_ff;
         end
         default: begin
            out_count_in = out_count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      cnt_ff        <= cnt_in;
      rd_pend_ff    <= rd_pend_in;
      rd_idx_ff     <= rd_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      cur_count_ff  <= cur_count_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_new_count = out_count_ff;
   assign rsp_status    = out_status_ff;

endmodule

// ===== rtl/kct_alu.sv =====
// Shared add/subtract unit used for tag compares and count updates.
`timescale 1ns / 1ps

module kct_alu
   import kct_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [RES_W-1:0] ext_a;
   logic [RES_W-1:0] ext_b;
   logic [RES_W-1:0] res;

   assign ext_a = {1'b0, req.a};
   assign ext_b = {1'b0, req.b};

   always_comb begin
      unique case (req.op)
         ALU_ADD: res = ext_a + ext_b;
         ALU_SUB: res = ext_a - ext_b;
         default: res = ext_a + ext_b;
      endcase
   end

   assign rsp.res  = res;
   assign rsp.zero = (res == '0);
   assign rsp.neg  = res[RES_W-1];

endmodule

// ===== rtl/kct_store.sv =====
// Entry storage: tag/count memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module kct_store
   import kct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  store_wr_type          wr,
   input  logic                  rd_en,
   input  logic [IDX_BITS-1:0]   rd_addr,
   output logic [TAG_BITS-1:0]   rd_tag,
   output logic [COUNT_BITS-1:0] rd_count,
   output logic [ENTRIES-1:0]    valid
);

   logic [TAG_BITS+COUNT_BITS-1:0] entry_mem [ENTRIES];
   logic [TAG_BITS+COUNT_BITS-1:0] rd_data_ff;
   logic [ENTRIES-1:0]             valid_ff;
   logic [ENTRIES-1:0]             valid_in;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         entry_mem[wr.addr] <= {wr.tag, wr.count};
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.set_valid) begin
         valid_in[wr.addr] = 1'b1;
      end else if (wr.clr_valid) begin
         valid_in[wr.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_tag   = rd_data_ff[TAG_BITS+COUNT_BITS-1:COUNT_BITS];
   assign rd_count = rd_data_ff[COUNT_BITS-1:0];
   assign valid    = valid_ff;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the keyed counter table: directed and random beats, scoreboard.
`timescale 1ns / 1ps

module tb
   import kct_pkg::*;
;

   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 850;
   localparam int POOL_SIZE    = 24;

   typedef struct {
      func_type                 func;
      logic [TAG_BITS-1:0]      tag;
      logic [FIELD_COUNT_W-1:0] new_count;
      logic [STATUS_W-1:0]      status;
   } table_answer_type;

   // Mirror of the table: predicts the answer of every accepted request beat.
   class tag_count_scoreboard;
      bit                    slot_used [ENTRIES];
      logic [TAG_BITS-1:0]   slot_tag  [ENTRIES];
      logic [COUNT_BITS-1:0] slot_count[ENTRIES];
      table_answer_type      pending_answers[$];
      int                    mismatches;

      function new();
         foreach (slot_used[s]) slot_used[s] = 1'b0;
         mismatches = 0;
      endfunction

      function void note_request(func_type func, logic [FIELD_TAG_W-1:0] tag,
                                 logic [FIELD_AMOUNT_W-1:0] amount);
         logic [TAG_BITS-1:0]   key;
         logic [COUNT_BITS:0]   sum;
         logic [COUNT_BITS:0]   wide_amount;
         int                    hit;
         int                    free_slot;
         int                    i;
         table_answer_type      ans;
         key         = tag[TAG_BITS-1:0];
         wide_amount = (COUNT_BITS + 1)'(amount);
         hit         = -1;
         free_slot   = -1;
         ans.func      = func;
         ans.tag       = key;
         ans.new_count = '0;
         ans.status    = STATUS_OK;
         if (key == '0) begin
            ans.status = STATUS_BAD_TAG;
         end else if (amount == '0) begin
            ans.status = STATUS_ZERO_AMOUNT;
         end else begin
            for (i = 0; i < ENTRIES; i++) begin
               if (slot_used[i] && slot_tag[i] == key && hit < 0) hit = i;
               if (!slot_used[i] && free_slot < 0) free_slot = i;
            end
            if (func == FUNC_ADD) begin
               if (hit >= 0) begin
                  sum = {1'b0, slot_count[hit]} + wide_amount;
                  if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
                  slot_count[hit] = sum[COUNT_BITS-1:0];
                  ans.new_count   = slot_count[hit];
               end else if (free_slot < 0) begin
                  ans.status = STATUS_FULL;
               end else begin
                  sum = wide_amount;
                  if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
                  slot_tag[free_slot]   = key;
                  slot_count[free_slot] = sum[COUNT_BITS-1:0];
                  slot_used[free_slot]  = 1'b1;
                  ans.new_count         = slot_count[free_slot];
               end
            end else begin
               if (hit < 0) begin
                  ans.status = STATUS_NOT_FOUND;
               end else if ({1'b0, slot_count[hit]} <= wide_amount) begin
                  slot_used[hit] = 1'b0;
               end else begin
                  slot_count[hit] = slot_count[hit] - amount[COUNT_BITS-1:0];
                  ans.new_count   = slot_count[hit];
               end
            end
         end
         pending_answers.push_back(ans);
      endfunction

      function void check_result(logic [FIELD_COUNT_W-1:0] got_count,
                                 logic [STATUS_W-1:0] got_status);
         table_answer_type want;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing pending: count %0d status %0d",
                        $time, got_count, got_status);
         end else begin
            want = pending_answers.pop_front();
            if (got_count !== want.new_count || got_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: %s tag %h: expected count %0d status %0d, ",
                            "got count %0d status %0d"},
                           $time, want.func.name(), want.tag, want.new_count, want.status,
                           got_count, got_status);
            end
         end
      endfunction
   endclass

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic                      req_func      = 1'b0;
   logic [FIELD_TAG_W-1:0]    req_tag       = '0;
   logic [FIELD_AMOUNT_W-1:0] req_amount    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic [FIELD_COUNT_W-1:0]  rsp_new_count;
   logic [STATUS_W-1:0]       rsp_status;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   logic [FIELD_TAG_W-1:0] tag_pool[POOL_SIZE];

   tag_count_scoreboard sb;

   keyed_counter_table_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_tag       (req_tag),
      .req_amount    (req_amount),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_new_count (rsp_new_count),
      .rsp_status    (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Results are checked before the request of the same edge is noted, since
   // a result can only belong to an older request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_new_count, rsp_status);
      if (!reset && req_valid && !req_stall)
         sb.note_request(func_type'(req_func), req_tag, req_amount);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** keyed_counter_table_unit: FAILED **");
      $finish;
   end

   // Returns at the edge where the beat is taken.
   task automatic send_request(func_type func, logic [FIELD_TAG_W-1:0] tag,
                               logic [FIELD_AMOUNT_W-1:0] amount);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < req_idle_pct) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_tag    <= tag;
      req_amount <= amount;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // The last beat is noted by the monitor at its own edge, so the task first waits for a clock edge.
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_requests(int count);
      func_type               func;
      logic [FIELD_TAG_W-1:0] tag;
      logic [FIELD_AMOUNT_W-1:0] amount;
      int                     pick;
      repeat (count) begin
         // Now and then a pool tag is replaced, so fresh tags keep arriving.
         if ($urandom_range(0, 99) < 3)
            tag_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom_range(1, 65535));
         func = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_REMOVE;
         pick = $urandom_range(0, 99);
         if (pick < 4)      tag = '0;
         else if (pick < 8) tag = 16'($urandom);
         else               tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
         pick = $urandom_range(0, 99);
         if (pick < 4)       amount = '0;
         else if (pick < 14) amount = 31'($urandom);
         else if (pick < 17) amount = '1;
         else                amount = 31'($urandom_range(1, 2000));
         send_request(func, tag, amount);
      end
   endtask

   initial begin
      int phase;
      int i;
      sb = new();
      foreach (tag_pool[p]) tag_pool[p] = 16'($urandom_range(1, 65535));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Rejections: the tag check comes before the amount check.
      send_request(FUNC_ADD, 16'h0000, 31'd5);
      send_request(FUNC_ADD, 16'h0000, 31'd0);
      send_request(FUNC_ADD, 16'h0007, 31'd0);
      send_request(FUNC_REMOVE, 16'h0007, 31'd0);
      send_request(FUNC_REMOVE, 16'h0009, 31'd1);
      // Saturation at the largest count, then a partial remove.
      send_request(FUNC_ADD, 16'hFFFF, '1);
      send_request(FUNC_ADD, 16'hFFFF, 31'd1);
      send_request(FUNC_REMOVE, 16'hFFFF, 31'd1);
      // A remove of exactly the count frees the entry.
      send_request(FUNC_ADD, 16'h0001, 31'd10);
      send_request(FUNC_REMOVE, 16'h0001, 31'd10);
      // Fill the table, then one more new tag finds it full.
      for (i = 0; i < ENTRIES - 1; i++) send_request(FUNC_ADD, 16'h5A00 + 16'(i), 31'(i + 1));
      send_request(FUNC_ADD, 16'hA5A5, 31'd3);
      send_request(FUNC_REMOVE, 16'hFFFF, '1);
      // Empty the table again so the random phases have room.
      for (i = 0; i < ENTRIES - 1; i++) send_request(FUNC_REMOVE, 16'h5A00 + 16'(i), '1);
      wait_for_answers();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin req_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         send_random_requests(RANDOM_ITEMS / 4);
         wait_for_answers();
      end

      repeat (3 * ENTRIES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
         $display("** keyed_counter_table_unit: PASSED **");
      end else begin
         $display("** keyed_counter_table_unit: FAILED **");
      end
      $finish;
   end

endmodule
